### hdl/mvlt_pkg.sv
// ----------------------------------------------------------------------------
// mvlt_pkg
// types and constants shared by the mac/vlan learning table blocks
// ----------------------------------------------------------------------------
package mvlt_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned TimeBits     = 32;
  localparam int unsigned IdxBits      = $clog2(TableEntries);
  localparam int unsigned CntBits      = 7;
  localparam int unsigned KeyBits      = 60;
  localparam int unsigned CfgIdxBits   = 3;

  typedef logic [IdxBits-1:0]  idx_t;
  typedef logic [IdxBits:0]    idx_cnt_t;
  typedef logic [TimeBits-1:0] time_t;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_LEARN  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_SWEEP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NEW      = 3'd1,
    ST_MOVED    = 3'd2,
    ST_FULL     = 3'd3,
    ST_DISABLED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_TABLE_ENABLE = 3'd0,
    REG_AGING_DELAY  = 3'd1,
    REG_UPLINK_MODE  = 3'd2,
    REG_GW_GID_HIGH  = 3'd3,
    REG_GW_GID_LOW   = 3'd4,
    REG_GW_QPN       = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_READ,
    FSM_WRITE,
    FSM_SWEEP_RD,
    FSM_SWEEP_WR,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] mac_address;
    logic [11:0] vlan_id;
    logic        refresh_flag;
    logic [63:0] gid_high;
    logic [63:0] gid_low;
    logic [23:0] queue_pair;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  status;
    logic [63:0] found_gid_high;
    logic [63:0] found_gid_low;
    logic [23:0] found_queue_pair;
    logic [6:0]  aged_count;
    logic [6:0]  in_use_count;
  } rsp_t;

  // one slot's payload in the entry memory
  typedef struct packed {
    logic [63:0]         gid_high;
    logic [63:0]         gid_low;
    logic [23:0]         queue_pair;
    logic                refresh;
    logic [TimeBits-1:0] last_seen;
  } entry_t;

  // key match result from the cam to the controller
  typedef struct packed {
    logic        found;
    idx_t        match_idx;
    logic        free_any;
    idx_t        free_idx;
  } cam_res_t;

endpackage

### hdl/mvlt_cam.sv
// ----------------------------------------------------------------------------
// mvlt_cam
// key store with valid bits; registered match and lowest-free search
// ----------------------------------------------------------------------------
module mvlt_cam import mvlt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [KeyBits-1:0] key_i,
  output cam_res_t           res_o,
  input  logic               wr_i,
  input  idx_t               wr_idx_i,
  input  logic [KeyBits-1:0] wr_key_i,
  input  logic               clr_i,
  input  idx_t               clr_idx_i,
  output logic [TableEntries-1:0] valid_o
);

  logic [TableEntries-1:0] valid_q;
  logic [KeyBits-1:0]      key_q [TableEntries];
  logic [TableEntries-1:0] hit_vec;
  cam_res_t                res_d, res_q;

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == key_i);
    end
  end

  // priority encoders, lowest index first
  always_comb begin
    res_d = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        res_d.found     = 1'b1;
        res_d.match_idx = idx_t'(i);
      end
      if (!valid_q[i]) begin
        res_d.free_any = 1'b1;
        res_d.free_idx = idx_t'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      res_q   <= '0;
    end else begin
      res_q <= res_d;
      if (wr_i) valid_q[wr_idx_i] <= 1'b1;
      if (clr_i) valid_q[clr_idx_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) key_q[wr_idx_i] <= wr_key_i;
  end

  assign res_o   = res_q;
  assign valid_o = valid_q;

  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec)) else $error("duplicate key in table");
  a_no_wr_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && clr_i)) else $error("learn and evict together");
  a_free_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.free_any |-> !valid_q[res_q.free_idx] || $past(wr_i) || $past(clr_i))
    else $error("free slot not free");

endmodule

### hdl/mvlt_ram.sv
// ----------------------------------------------------------------------------
// mvlt_ram
// entry payload memory, one write and one registered read port
// ----------------------------------------------------------------------------
module mvlt_ram import mvlt_pkg::*; (
  input  logic   clk_i,
  input  logic   rd_i,
  input  idx_t   rd_idx_i,
  output entry_t rd_data_o,
  input  logic   wr_i,
  input  idx_t   wr_idx_i,
  input  entry_t wr_data_i
);

  entry_t mem [TableEntries];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) mem[wr_idx_i] <= wr_data_i;
    if (rd_i) rd_q <= mem[rd_idx_i];
  end

  assign rd_data_o = rd_q;

endmodule

### hdl/mac_vlan_learning_table_aging_core.sv
// ----------------------------------------------------------------------------
// mac_vlan_learning_table_aging_core
// mac/vlan forwarding table with learn, lookup, time tick and aging sweep
// ----------------------------------------------------------------------------
//  channel   | signals                          | direction
//  ----------+----------------------------------+----------
//  command   | start_i, busy_o, req_i           | in
//  result    | done_o, rsp_o                    | out
//  config    | cfg_valid_i, cfg_ready_o,        | in
//            | cfg_index_i, cfg_data_i          |
//
// lookup and learn go from start to done through key match (registered at the
// accepting edge), entry read, modify and write back, result and strobe;
// tick: straight to result and strobe
// sweep: a read and a write per slot through the single entry memory port pair
// reset clears valid bits, time and control registers and sets config defaults; entry memory is not cleared
// the result strobe lasts one cycle and is not held off by the receiver
// ----------------------------------------------------------------------------
module mac_vlan_learning_table_aging_core import mvlt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  req_t                  req_i,
  output logic                  done_o,
  output rsp_t                  rsp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [63:0]           cfg_data_i
);

  // configuration registers
  logic        enable_q;
  time_t       delay_q;
  logic        uplink_q;
  logic [63:0] gw_high_q, gw_low_q;
  logic [23:0] gw_qpn_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      delay_q  <= time_t'(300);
      uplink_q <= 1'b0;
      gw_high_q <= '0;
      gw_low_q <= '0;
      gw_qpn_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_TABLE_ENABLE: enable_q  <= cfg_data_i[0];
        REG_AGING_DELAY:  delay_q   <= cfg_data_i[TimeBits-1:0];
        REG_UPLINK_MODE:  uplink_q  <= cfg_data_i[0];
        REG_GW_GID_HIGH:  gw_high_q <= cfg_data_i;
        REG_GW_GID_LOW:   gw_low_q  <= cfg_data_i;
        REG_GW_QPN:       gw_qpn_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  fsm_e     state_q, state_d;
  req_t     req_q;
  time_t    time_q;
  idx_t     idx_q, idx_d;
  logic     found_q, found_d;
  logic     last_q;
  logic [CntBits-1:0] aged_q, kept_q;
  rsp_t     rsp_q, rsp_d;
  logic     done_q;

  cam_res_t cam_res;
  logic [TableEntries-1:0] valid_vec;
  logic     cam_wr, cam_clr;
  logic     ram_rd, ram_wr;
  idx_t     ram_rd_idx;
  entry_t   ram_rd_data, ram_wr_data;

  // learn item with gateway queue pair substitution applied
  logic [23:0] qp_eff;
  assign qp_eff = (uplink_q && req_q.gid_high == gw_high_q && req_q.gid_low == gw_low_q)
                  ? gw_qpn_q : req_q.queue_pair;

  // match the key of the item being accepted so the result is ready in scan
  logic [KeyBits-1:0] cam_key;
  assign cam_key = (state_q == FSM_IDLE) ? {req_i.mac_address, req_i.vlan_id}
                                         : {req_q.mac_address, req_q.vlan_id};

  mvlt_cam u_cam (
    .clk_i, .rst_ni,
    .key_i    (cam_key),
    .res_o    (cam_res),
    .wr_i     (cam_wr),
    .wr_idx_i (idx_q),
    .wr_key_i ({req_q.mac_address, req_q.vlan_id}),
    .clr_i    (cam_clr),
    .clr_idx_i(idx_q),
    .valid_o  (valid_vec)
  );

  mvlt_ram u_ram (
    .clk_i,
    .rd_i     (ram_rd),
    .rd_idx_i (ram_rd_idx),
    .rd_data_o(ram_rd_data),
    .wr_i     (ram_wr),
    .wr_idx_i (idx_q),
    .wr_data_i(ram_wr_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (start_i) begin
        case (cmd_e'(req_i.command))
          CMD_SWEEP: state_d = enable_q ? FSM_SWEEP_RD : FSM_DONE;
          CMD_TICK:  state_d = FSM_DONE;
          default:   state_d = FSM_SCAN;
        endcase
      end
      FSM_SCAN:     state_d = FSM_READ;
      FSM_READ:     state_d = FSM_WRITE;
      FSM_WRITE:    state_d = FSM_DONE;
      FSM_SWEEP_RD: state_d = FSM_SWEEP_WR;
      FSM_SWEEP_WR: state_d = last_q ? FSM_DONE : FSM_SWEEP_RD;
      FSM_DONE:     state_d = FSM_IDLE;
      default:      state_d = FSM_IDLE;
    endcase
  end

  // outputs and datapath control
  time_t age;
  assign age = time_q - ram_rd_data.last_seen;

  always_comb begin
    cam_wr = 1'b0;
    cam_clr = 1'b0;
    ram_rd = 1'b0;
    ram_wr = 1'b0;
    ram_rd_idx = idx_q;
    ram_wr_data = ram_rd_data;
    idx_d = idx_q;
    found_d = found_q;
    rsp_d = rsp_q;
    case (state_q)
      FSM_IDLE: begin
        rsp_d = '0;
        idx_d = '0;
        if (start_i && cmd_e'(req_i.command) == CMD_SWEEP && !enable_q) begin
          rsp_d.status = ST_DISABLED;
        end
      end
      FSM_SCAN: begin
        found_d = cam_res.found;
        idx_d = cam_res.found ? cam_res.match_idx : cam_res.free_idx;
        ram_rd = 1'b1;
        ram_rd_idx = cam_res.match_idx;
      end
      FSM_READ: ;
      FSM_WRITE: begin
        ram_wr_data.last_seen = time_q;
        if (cmd_e'(req_q.command) == CMD_LOOKUP) begin
          if (found_q) begin
            ram_wr = 1'b1;
            if (req_q.refresh_flag) ram_wr_data.refresh = 1'b1;
            rsp_d.hit = 1'b1;
          end
        end else if (found_q) begin
          ram_wr = 1'b1;
          ram_wr_data.refresh = 1'b1;
          ram_wr_data.gid_high = req_q.gid_high;
          ram_wr_data.gid_low = req_q.gid_low;
          if (qp_eff != '0) ram_wr_data.queue_pair = qp_eff;
          if (ram_rd_data.gid_high != req_q.gid_high || ram_rd_data.gid_low != req_q.gid_low)
            rsp_d.status = ST_MOVED;
          rsp_d.hit = 1'b1;
        end else if (!valid_vec[idx_q]) begin
          ram_wr = 1'b1;
          cam_wr = 1'b1;
          ram_wr_data.refresh = 1'b1;
          ram_wr_data.gid_high = req_q.gid_high;
          ram_wr_data.gid_low = req_q.gid_low;
          ram_wr_data.queue_pair = qp_eff;
          rsp_d.status = ST_NEW;
        end else begin
          rsp_d.status = ST_FULL;
        end
        if (rsp_d.hit) begin
          rsp_d.found_gid_high = ram_wr_data.gid_high;
          rsp_d.found_gid_low = ram_wr_data.gid_low;
          rsp_d.found_queue_pair = ram_wr_data.queue_pair;
        end
      end
      FSM_SWEEP_RD: ram_rd = 1'b1;
      FSM_SWEEP_WR: begin
        if (valid_vec[idx_q]) begin
          if (ram_rd_data.refresh) begin
            ram_wr = 1'b1;
            ram_wr_data.refresh = 1'b0;
          end else if (age >= delay_q) begin
            cam_clr = 1'b1;
          end
        end
        idx_d = idx_q + idx_t'(1);
      end
      FSM_DONE: begin
        if (cmd_e'(req_q.command) == CMD_SWEEP && enable_q) begin
          rsp_d.aged_count = aged_q;
          rsp_d.in_use_count = kept_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      time_q  <= '0;
      done_q  <= 1'b0;
      idx_q   <= '0;
      found_q <= 1'b0;
      aged_q  <= '0;
      kept_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      done_q  <= (state_q == FSM_DONE);
      if (state_q == FSM_IDLE) begin
        aged_q <= '0;
        kept_q <= '0;
        last_q <= 1'b0;
        if (start_i && cmd_e'(req_i.command) == CMD_TICK) time_q <= time_q + time_t'(1);
      end
      if (state_q == FSM_SWEEP_RD) last_q <= (idx_q == idx_t'(TableEntries - 1));
      if (state_q == FSM_SWEEP_WR && valid_vec[idx_q]) begin
        if (cam_clr) aged_q <= aged_q + CntBits'(1);
        else kept_q <= kept_q + CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FSM_IDLE && start_i) req_q <= req_i;
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != FSM_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than a cycle");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == FSM_DONE)) else $error("stray result");
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_IDLE) |-> (cam_wr == 1'b0 && cam_clr == 1'b0))
    else $error("table written while idle");

endmodule
